// ===== hw/rtl/segx_pkg.sv =====
`timescale 1ns / 1ps
// Shared types for the segment intersection test pipeline.
// No dependencies; imported by every module of the block.
package segx_pkg;

	// Bounding box results for the collinear case, one flag per endpoint.
	typedef struct packed {
		logic q0_in_first;   // second start inside the first segment's box
		logic q1_in_first;   // second end inside the first segment's box
		logic p0_in_second;  // first start inside the second segment's box
		logic p1_in_second;  // first end inside the second segment's box
	} segx_box_t;

endpackage

// ===== hw/rtl/segx_diff.sv =====
`timescale 1ns / 1ps
// Stage 1: edge vectors r, s, pq and endpoint bounding box checks.
// Depends on segx_pkg.
module segx_diff import segx_pkg::*; #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic signed [COORD_WIDTH-1:0] p0x,
	input  logic signed [COORD_WIDTH-1:0] p0y,
	input  logic signed [COORD_WIDTH-1:0] p1x,
	input  logic signed [COORD_WIDTH-1:0] p1y,
	input  logic signed [COORD_WIDTH-1:0] q0x,
	input  logic signed [COORD_WIDTH-1:0] q0y,
	input  logic signed [COORD_WIDTH-1:0] q1x,
	input  logic signed [COORD_WIDTH-1:0] q1y,
	output logic                          v_s1,
	output logic signed [COORD_WIDTH:0]   rx_s1,
	output logic signed [COORD_WIDTH:0]   ry_s1,
	output logic signed [COORD_WIDTH:0]   sx_s1,
	output logic signed [COORD_WIDTH:0]   sy_s1,
	output logic signed [COORD_WIDTH:0]   pqx_s1,
	output logic signed [COORD_WIDTH:0]   pqy_s1,
	output segx_box_t                     box_s1
);

	logic signed [COORD_WIDTH:0] rx, ry, sx, sy, pqx, pqy;
	segx_box_t box;

	// Differences are one bit wider than the coordinates, so they never wrap.
	always_comb begin
		rx  = {p1x[COORD_WIDTH-1], p1x} - {p0x[COORD_WIDTH-1], p0x};
		ry  = {p1y[COORD_WIDTH-1], p1y} - {p0y[COORD_WIDTH-1], p0y};
		sx  = {q1x[COORD_WIDTH-1], q1x} - {q0x[COORD_WIDTH-1], q0x};
		sy  = {q1y[COORD_WIDTH-1], q1y} - {q0y[COORD_WIDTH-1], q0y};
		pqx = {q0x[COORD_WIDTH-1], q0x} - {p0x[COORD_WIDTH-1], p0x};
		pqy = {q0y[COORD_WIDTH-1], q0y} - {p0y[COORD_WIDTH-1], p0y};
	end

	// A point lies above the minimum of two ends when it lies above either of
	// them, and below the maximum when it lies below either of them.
	always_comb begin
		box.q0_in_first  = (q0x >= p0x || q0x >= p1x) && (q0x <= p0x || q0x <= p1x) &&
		                   (q0y >= p0y || q0y >= p1y) && (q0y <= p0y || q0y <= p1y);
		box.q1_in_first  = (q1x >= p0x || q1x >= p1x) && (q1x <= p0x || q1x <= p1x) &&
		                   (q1y >= p0y || q1y >= p1y) && (q1y <= p0y || q1y <= p1y);
		box.p0_in_second = (p0x >= q0x || p0x >= q1x) && (p0x <= q0x || p0x <= q1x) &&
		                   (p0y >= q0y || p0y >= q1y) && (p0y <= q0y || p0y <= q1y);
		box.p1_in_second = (p1x >= q0x || p1x >= q1x) && (p1x <= q0x || p1x <= q1x) &&
		                   (p1y >= q0y || p1y >= q1y) && (p1y <= q0y || p1y <= q1y);
	end

	// Valid bit of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	// Payload registers of the stage.
	always_ff @(posedge clk) begin
		rx_s1  <= rx;
		ry_s1  <= ry;
		sx_s1  <= sx;
		sy_s1  <= sy;
		pqx_s1 <= pqx;
		pqy_s1 <= pqy;
		box_s1 <= box;
	end

endmodule

// ===== hw/rtl/segx_cross.sv =====
`timescale 1ns / 1ps
// Stages 2 and 3: six products, then the three exact cross products.
// Depends on segx_pkg.
module segx_cross import segx_pkg::*; #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            v_s1,
	input  logic signed [COORD_WIDTH:0]     rx_s1,
	input  logic signed [COORD_WIDTH:0]     ry_s1,
	input  logic signed [COORD_WIDTH:0]     sx_s1,
	input  logic signed [COORD_WIDTH:0]     sy_s1,
	input  logic signed [COORD_WIDTH:0]     pqx_s1,
	input  logic signed [COORD_WIDTH:0]     pqy_s1,
	input  segx_box_t                       box_s1,
	output logic                            v_s3,
	output logic signed [2*COORD_WIDTH+2:0] rxs_s3,
	output logic signed [2*COORD_WIDTH+2:0] pqxr_s3,
	output logic signed [2*COORD_WIDTH+2:0] pqxs_s3,
	output segx_box_t                       box_s3
);

	localparam int PW = 2 * COORD_WIDTH + 2;
	localparam int CW = PW + 1;

	logic                 v_s2;
	logic signed [PW-1:0] rx_sy_s2, ry_sx_s2;
	logic signed [PW-1:0] pqx_ry_s2, pqy_rx_s2;
	logic signed [PW-1:0] pqx_sy_s2, pqy_sx_s2;
	segx_box_t            box_s2;

	// Valid bits of both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 2: each product is held at full width.
	always_ff @(posedge clk) begin
		rx_sy_s2  <= PW'(rx_s1) * PW'(sy_s1);
		ry_sx_s2  <= PW'(ry_s1) * PW'(sx_s1);
		pqx_ry_s2 <= PW'(pqx_s1) * PW'(ry_s1);
		pqy_rx_s2 <= PW'(pqy_s1) * PW'(rx_s1);
		pqx_sy_s2 <= PW'(pqx_s1) * PW'(sy_s1);
		pqy_sx_s2 <= PW'(pqy_s1) * PW'(sx_s1);
		box_s2    <= box_s1;
	end

	// Stage 3: cross products with one guard bit for the subtraction.
	always_ff @(posedge clk) begin
		rxs_s3  <= CW'(rx_sy_s2) - CW'(ry_sx_s2);
		pqxr_s3 <= CW'(pqx_ry_s2) - CW'(pqy_rx_s2);
		pqxs_s3 <= CW'(pqx_sy_s2) - CW'(pqy_sx_s2);
		box_s3  <= box_s2;
	end

endmodule

// ===== hw/rtl/segx_decide.sv =====
`timescale 1ns / 1ps
// Stage 4: classifies the pair and registers the touching flag.
// Depends on segx_pkg.
module segx_decide import segx_pkg::*; #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            v_s3,
	input  logic signed [2*COORD_WIDTH+2:0] rxs_s3,
	input  logic signed [2*COORD_WIDTH+2:0] pqxr_s3,
	input  logic signed [2*COORD_WIDTH+2:0] pqxs_s3,
	input  segx_box_t                       box_s3,
	output logic                            v_s4,
	output logic                            hit_s4
);

	localparam int CW = 2 * COORD_WIDTH + 3;

	logic signed [CW-1:0] zero;
	logic t_in_unit, u_in_unit, collinear_hit, hit;

	assign zero = '0;

	// t and u lie in [0,1] when the numerator sits between zero and r x s.
	always_comb begin
		if (!rxs_s3[CW-1]) begin
			t_in_unit = (pqxs_s3 >= zero) && (pqxs_s3 <= rxs_s3);
			u_in_unit = (pqxr_s3 >= zero) && (pqxr_s3 <= rxs_s3);
		end else begin
			t_in_unit = (pqxs_s3 <= zero) && (rxs_s3 <= pqxs_s3);
			u_in_unit = (pqxr_s3 <= zero) && (rxs_s3 <= pqxr_s3);
		end
	end

	// With r x s and pq x r both zero, the second segment's ends are on the
	// first segment's line; the first segment's ends are on the second
	// segment's line only when pq x s is zero as well.
	always_comb begin
		collinear_hit = box_s3.q0_in_first || box_s3.q1_in_first ||
		                ((pqxs_s3 == zero) && (box_s3.p0_in_second || box_s3.p1_in_second));
		if (rxs_s3 != zero) begin
			hit = t_in_unit && u_in_unit;
		end else if (pqxr_s3 != zero) begin
			hit = 1'b0;
		end else begin
			hit = collinear_hit;
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		hit_s4 <= hit;
	end

endmodule

// ===== hw/rtl/segment_intersection_test.sv =====
`timescale 1ns / 1ps
// Top level of the segment intersection test: four pipeline stages.
// Depends on segx_pkg, segx_diff, segx_cross and segx_decide.
//
//  Channel   Handshake        Payload
//  --------  ---------------  ---------------------------------------------
//  request   start, busy      first/second start/end x/y (COORD_WIDTH each)
//  result    done             touching (1 bit)
//
// A request is taken at every edge where start is high; busy stays low, as
// the pipeline never stalls. Each request gives one result, on done for a
// single cycle, in request order. The depth is set by the difference stage,
// the multiplier stage, the cross product subtraction and the final
// classification. Reset clears only the valid bits.
module segment_intersection_test import segx_pkg::*; #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] first_start_x,
	input  logic signed [COORD_WIDTH-1:0] first_start_y,
	input  logic signed [COORD_WIDTH-1:0] first_end_x,
	input  logic signed [COORD_WIDTH-1:0] first_end_y,
	input  logic signed [COORD_WIDTH-1:0] second_start_x,
	input  logic signed [COORD_WIDTH-1:0] second_start_y,
	input  logic signed [COORD_WIDTH-1:0] second_end_x,
	input  logic signed [COORD_WIDTH-1:0] second_end_y,
	output logic                          done,
	output logic                          touching
);

	logic                            v_s1, v_s3;
	logic signed [COORD_WIDTH:0]     rx_s1, ry_s1, sx_s1, sy_s1, pqx_s1, pqy_s1;
	logic signed [2*COORD_WIDTH+2:0] rxs_s3, pqxr_s3, pqxs_s3;
	segx_box_t                       box_s1, box_s3;

	// The pipeline advances every cycle, so requests are never held off.
	assign busy = 1'b0;

	// Edge vectors and bounding box checks.
	segx_diff #(.COORD_WIDTH(COORD_WIDTH)) u_diff (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.p0x      (first_start_x),
		.p0y      (first_start_y),
		.p1x      (first_end_x),
		.p1y      (first_end_y),
		.q0x      (second_start_x),
		.q0y      (second_start_y),
		.q1x      (second_end_x),
		.q1y      (second_end_y),
		.v_s1     (v_s1),
		.rx_s1    (rx_s1),
		.ry_s1    (ry_s1),
		.sx_s1    (sx_s1),
		.sy_s1    (sy_s1),
		.pqx_s1   (pqx_s1),
		.pqy_s1   (pqy_s1),
		.box_s1   (box_s1)
	);

	// Exact cross products.
	segx_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
		.clk     (clk),
		.arst_n  (arst_n),
		.v_s1    (v_s1),
		.rx_s1   (rx_s1),
		.ry_s1   (ry_s1),
		.sx_s1   (sx_s1),
		.sy_s1   (sy_s1),
		.pqx_s1  (pqx_s1),
		.pqy_s1  (pqy_s1),
		.box_s1  (box_s1),
		.v_s3    (v_s3),
		.rxs_s3  (rxs_s3),
		.pqxr_s3 (pqxr_s3),
		.pqxs_s3 (pqxs_s3),
		.box_s3  (box_s3)
	);

	// Classification and result register.
	segx_decide #(.COORD_WIDTH(COORD_WIDTH)) u_decide (
		.clk     (clk),
		.arst_n  (arst_n),
		.v_s3    (v_s3),
		.rxs_s3  (rxs_s3),
		.pqxr_s3 (pqxr_s3),
		.pqxs_s3 (pqxs_s3),
		.box_s3  (box_s3),
		.v_s4    (done),
		.hit_s4  (touching)
	);

endmodule
